// ===== rtl/core/dllc_pkg.sv =====
// dllc_pkg: shared constants, action codes and control struct for the list engine
// no dependencies
package dllc_pkg;
  localparam int POOL_NODES_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ACT_CLEAR      = 4'd0,
    ACT_INS_FIRST  = 4'd1,
    ACT_INS_LAST   = 4'd2,
    ACT_CUR_FIRST  = 4'd3,
    ACT_CUR_LAST   = 4'd4,
    ACT_DEL_FIRST  = 4'd5,
    ACT_DEL_LAST   = 4'd6,
    ACT_DEL_AFTER  = 4'd7,
    ACT_DEL_BEFORE = 4'd8,
    ACT_INS_AFTER  = 4'd9,
    ACT_INS_BEFORE = 4'd10,
    ACT_OVERWRITE  = 4'd11,
    ACT_NEXT       = 4'd12,
    ACT_PREV       = 4'd13,
    ACT_QUERY      = 4'd14,
    ACT_SPARE      = 4'd15
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture item, read cursor links
    logic exec;    // perform update
    logic rd_out;  // relink around deleted node
    logic rd_out2; // read head value
    logic rd_out3; // read tail and cursor values, build result
  } dp_cmd_t;
endpackage

// ===== rtl/core/dllc_ctrl.sv =====
// dllc_ctrl: sequencer for the list engine, one item at a time
// depends on dllc_pkg
module dllc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dllc_pkg::dp_cmd_t cmd
);
  import dllc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RD1, S_RD2, S_RD3, S_OUT} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.rd_out  = (state == S_RD1);
    cmd.rd_out2 = (state == S_RD2);
    cmd.rd_out3 = (state == S_RD3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_RD3;
        S_RD3:  state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/dllc_datapath.sv =====
// dllc_datapath: node pool memories, free map, head/tail/cursor and result registers
// depends on dllc_pkg
module dllc_datapath #(
  parameter int POOL_NODES = dllc_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = dllc_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dllc_pkg::dp_cmd_t        cmd,
  input  logic [3:0]               action,
  input  logic signed [31:0]       value,
  output logic signed [31:0]       first_value,
  output logic signed [31:0]       last_value,
  output logic signed [31:0]       cursor_value,
  output logic                     list_nonempty,
  output logic                     cursor_active,
  output logic                     out_of_memory
);
  import dllc_pkg::*;

  localparam int AW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

  logic [VALUE_BITS-1:0] node_data [POOL_NODES];
  logic [LW-1:0] next_link [POOL_NODES];
  logic [LW-1:0] prev_link [POOL_NODES];
  logic [POOL_NODES-1:0] free_map;
  logic [LW-1:0] head, tail, cursor;

  action_t act;
  logic [VALUE_BITS-1:0] val;
  logic [LW-1:0] cur_next, cur_prev;   // links of cursor node
  logic [LW-1:0] tgt_prev, tgt_next;   // links of delete target
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] hv, tv;

  // lowest free slot
  logic [LW-1:0] free_idx;
  always_comb begin
    free_idx = NIL;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (free_map[i]) free_idx = LW'(i);
    end
  end

  function automatic logic [AW-1:0] ix(input logic [LW-1:0] n);
    return n[AW-1:0];
  endfunction

  // delete target chosen from the captured action and the current head, tail or cursor links
  logic [LW-1:0] tgt;
  always_comb begin
    tgt = NIL;
    case (act)
      ACT_DEL_FIRST:  tgt = head;
      ACT_DEL_LAST:   tgt = tail;
      ACT_DEL_AFTER:  tgt = (cursor != NIL) ? cur_next : NIL;
      ACT_DEL_BEFORE: tgt = (cursor != NIL) ? cur_prev : NIL;
      default:        tgt = NIL;
    endcase
  end

  // second read stage: links of delete target
  logic tgt_loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map      <= '1;
      head          <= NIL;
      tail          <= NIL;
      cursor        <= NIL;
      out_of_memory <= 1'b0;
      tgt_loaded    <= 1'b0;
    end else begin
      if (cmd.load) begin
        act <= action_t'(action);
        val <= VALUE_BITS'(value);
        out_of_memory <= 1'b0;
        if (cursor != NIL) begin
          cur_next <= next_link[ix(cursor)];
          cur_prev <= prev_link[ix(cursor)];
        end else begin
          cur_next <= NIL;
          cur_prev <= NIL;
        end
        tgt_loaded <= 1'b0;
      end
      if (cmd.exec) begin
        case (act)
          ACT_CLEAR: begin
            free_map <= '1;
            head <= NIL;
            tail <= NIL;
            cursor <= NIL;
          end
          ACT_INS_FIRST, ACT_INS_LAST, ACT_INS_AFTER, ACT_INS_BEFORE: begin
            logic [LW-1:0] a, b;
            a = NIL;
            b = NIL;
            case (act)
              ACT_INS_FIRST:  begin a = NIL;    b = head;     end
              ACT_INS_LAST:   begin a = tail;   b = NIL;      end
              ACT_INS_AFTER:  begin a = cursor; b = cur_next; end
              default:        begin a = cur_prev; b = cursor; end
            endcase
            if ((act == ACT_INS_AFTER || act == ACT_INS_BEFORE) && cursor == NIL) begin
            end else if (free_idx == NIL) begin
              out_of_memory <= 1'b1;
            end else begin
              free_map[ix(free_idx)] <= 1'b0;
              node_data[ix(free_idx)] <= val;
              prev_link[ix(free_idx)] <= a;
              next_link[ix(free_idx)] <= b;
              if (a != NIL) next_link[ix(a)] <= free_idx;
              else head <= free_idx;
              if (b != NIL) prev_link[ix(b)] <= free_idx;
              else tail <= free_idx;
            end
          end
          ACT_CUR_FIRST: cursor <= head;
          ACT_CUR_LAST:  cursor <= tail;
          ACT_OVERWRITE: if (cursor != NIL) node_data[ix(cursor)] <= val;
          ACT_NEXT:      if (cursor != NIL) cursor <= cur_next;
          ACT_PREV:      if (cursor != NIL) cursor <= cur_prev;
          ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AFTER, ACT_DEL_BEFORE: begin
            if (tgt != NIL) begin
              tgt_prev <= prev_link[ix(tgt)];
              tgt_next <= next_link[ix(tgt)];
              tgt_loaded <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // relink around deleted node
      if (cmd.rd_out && tgt_loaded) begin
        if (tgt_prev != NIL) next_link[ix(tgt_prev)] <= tgt_next;
        else head <= tgt_next;
        if (tgt_next != NIL) prev_link[ix(tgt_next)] <= tgt_prev;
        else tail <= tgt_prev;
        if (cursor == tgt) cursor <= NIL;
        free_map[ix(tgt)] <= 1'b1;
      end
      if (cmd.rd_out2) rd_data <= (head != NIL) ? node_data[ix(head)] : '0;
      if (cmd.rd_out3) begin
        hv <= rd_data;
        rd_data <= (tail != NIL) ? node_data[ix(tail)] : '0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.rd_out3) begin
      list_nonempty <= (head != NIL);
      cursor_active <= (cursor != NIL);
      cursor_value  <= 32'(signed'((cursor != NIL) ? node_data[ix(cursor)]
                                                     : {VALUE_BITS{1'b0}}));
    end
  end

  assign first_value = 32'(signed'(hv));
  assign last_value  = 32'(signed'(rd_data));
endmodule

// ===== rtl/core/doubly_linked_list_cursor_engine.sv =====
// doubly_linked_list_cursor_engine: top level, joins sequencer and datapath
// depends on dllc_pkg, dllc_ctrl, dllc_datapath
// One item at a time: the cursor links are read at acceptance, then come the
// update (or the delete target link read), the relink on delete, the head read,
// and the tail and cursor read, after which the result is valid. The result is
// held until taken and the next item can be accepted in the cycle after. No
// clearing pass.
module doubly_linked_list_cursor_engine #(
  parameter int POOL_NODES = dllc_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = dllc_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] first_value,
  output logic signed [31:0] last_value,
  output logic signed [31:0] cursor_value,
  output logic               list_nonempty,
  output logic               cursor_active,
  output logic               out_of_memory
);
  import dllc_pkg::*;

  dp_cmd_t cmd;

  dllc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  dllc_datapath #(.POOL_NODES(POOL_NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd, .action, .value, .first_value, .last_value,
    .cursor_value, .list_nonempty, .cursor_active, .out_of_memory
  );
endmodule
